/* src/rbd_pkg.sv */
package rbd_pkg;

  // fixed field widths of the stream and register ports
  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 32;
  localparam int DATA_OUT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 4;
  localparam int S_TDATA_W    = 32;
  localparam int S_TUSER_W    = 3;
  localparam int M_TDATA_W    = 40;
  localparam int M_TUSER_W    = 2;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int RING_LEN_W   = 5;

  // defaults for the top-level parameters, and the reset value and minimum of ring_len
  localparam int MAX_SLOTS_DEF     = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int RING_LEN_RESET    = 16;
  localparam int RING_LEN_MIN      = 2;

  // register index of ring_len
  localparam logic REG_RING_LEN = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // result of one command, minus the element read from the store
  typedef struct packed {
    logic                   has_data;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
    logic                   is_full;
    logic                   is_empty;
  } pend_t;

endpackage

/* src/rbd_store.sv */
module rbd_store #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/rbd_ctrl.sv */
module rbd_ctrl #(
  parameter int MAX_SLOTS = 16,
  parameter int DATA_W    = 32,
  parameter int PTR_W     = 4,
  parameter int LEN_W     = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  // command side
  input  logic                            accept,
  input  logic [rbd_pkg::CMD_W-1:0]       command,
  input  logic [rbd_pkg::VALUE_W-1:0]     value,
  output rbd_pkg::pend_t                  pend,
  // store access
  output logic                            wr_en,
  output logic [PTR_W-1:0]                wr_addr,
  output logic [DATA_W-1:0]               wr_data,
  output logic                            rd_en,
  output logic [PTR_W-1:0]                rd_addr,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rbd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rbd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rbd_pkg::APB_DATA_W-1:0]  prdata
);

  import rbd_pkg::*;

  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] front_next;
  logic [PTR_W-1:0] back;
  logic [PTR_W-1:0] back_next;
  logic [PTR_W-1:0] count;
  logic [PTR_W-1:0] count_next;
  logic [LEN_W-1:0] ring_len;
  logic [LEN_W-1:0] ring_len_next;
  logic [LEN_W-1:0] last_slot;
  logic [PTR_W-1:0] front_inc;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] back_inc;
  logic [PTR_W-1:0] back_dec;
  logic             full;
  logic             empty;
  logic             cfg_write;
  logic [RING_LEN_W-1:0] wr_len;
  logic [PTR_W+COUNT_OUT_W-1:0] count_ext;
  status_t          status;
  logic             has_data;
  logic             do_wr;
  logic             do_rd;

  // pointer steps with wrap at ring_len
  assign last_slot = ring_len - 1'b1;
  assign front_inc = ({{LEN_W{1'b0}}, front} == {{PTR_W{1'b0}}, last_slot}) ?
                     '0 : front + 1'b1;
  assign back_inc  = ({{LEN_W{1'b0}}, back} == {{PTR_W{1'b0}}, last_slot}) ?
                     '0 : back + 1'b1;
  assign front_dec = (front == '0) ? last_slot[PTR_W-1:0] : front - 1'b1;
  assign back_dec  = (back == '0) ? last_slot[PTR_W-1:0] : back - 1'b1;

  assign full  = ({{LEN_W{1'b0}}, count} == {{PTR_W{1'b0}}, last_slot});
  assign empty = (count == '0);

  // command decode
  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    status     = ST_DONE;
    has_data   = 1'b0;
    do_wr      = 1'b0;
    do_rd      = 1'b0;
    wr_addr    = back;
    rd_addr    = front;
    case (command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_wr      = 1'b1;
          wr_addr    = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_wr      = 1'b1;
          wr_addr    = back;
          back_next  = back_inc;
          count_next = count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd      = 1'b1;
          has_data   = 1'b1;
          rd_addr    = front;
          front_next = front_inc;
          count_next = count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd      = 1'b1;
          has_data   = 1'b1;
          rd_addr    = back_dec;
          back_next  = back_dec;
          count_next = count - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd    = 1'b1;
          has_data = 1'b1;
          rd_addr  = front;
        end
      end
      CMD_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_rd    = 1'b1;
          has_data = 1'b1;
          rd_addr  = back_dec;
        end
      end
      CMD_CLEAR: begin
        front_next = '0;
        back_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign wr_en   = accept && do_wr;
  assign rd_en   = accept && do_rd;
  assign wr_data = value[DATA_W-1:0];

  // result fields known at acceptance
  assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};
  always_comb begin
    pend.has_data = has_data;
    pend.status   = status;
    pend.count    = count_ext[COUNT_OUT_W-1:0];
    pend.is_full  = ({{LEN_W{1'b0}}, count_next} == {{PTR_W{1'b0}}, last_slot});
    pend.is_empty = (count_next == '0);
  end

  // register write with clamping of ring_len
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RING_LEN);
  assign wr_len    = pwdata[RING_LEN_W-1:0];
  always_comb begin
    if (int'(wr_len) < RING_LEN_MIN) begin
      ring_len_next = LEN_W'(RING_LEN_MIN);
    end else if (int'(wr_len) > MAX_SLOTS) begin
      ring_len_next = LEN_W'(MAX_SLOTS);
    end else begin
      ring_len_next = LEN_W'(wr_len);
    end
  end

  assign prdata = (paddr[2] == REG_RING_LEN) ?
                  APB_DATA_W'(ring_len) : '0;

  // pointer and length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      back     <= '0;
      count    <= '0;
      ring_len <= (RING_LEN_RESET > MAX_SLOTS) ? LEN_W'(MAX_SLOTS) :
                  LEN_W'(RING_LEN_RESET);
    end else if (cfg_write) begin
      front    <= '0;
      back     <= '0;
      count    <= '0;
      ring_len <= ring_len_next;
    end else if (accept) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

endmodule

/* src/rbd_out.sv */
module rbd_out #(
  parameter int DATA_W = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  rbd_pkg::pend_t                 pend_in,
  input  logic [DATA_W-1:0]              rd_data,
  output logic                           ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rbd_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [rbd_pkg::M_TUSER_W-1:0]  m_tuser
);

  import rbd_pkg::*;

  pend_t pend;
  logic  pend_valid;
  logic  take;
  logic [DATA_W+DATA_OUT_W-1:0] data_ext;
  logic [DATA_OUT_W-1:0]        data_out;

  // the read stage moves on when the output register is free or drains
  assign take  = pend_valid && (!m_tvalid || m_tready);
  assign ready = !pend_valid || take;

  assign data_ext = {{DATA_OUT_W{1'b0}}, rd_data};
  assign data_out = pend.has_data ? data_ext[DATA_OUT_W-1:0] : '0;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_in;
    end
    if (take) begin
      m_tdata <= {2'b00, pend.is_empty, pend.is_full, pend.count, data_out};
      m_tuser <= pend.status;
    end
  end

endmodule

/* src/ring_buffer_deque.sv */
// Double-ended queue in a circular store of ring_len slots (at most ring_len-1
// elements). Commands arrive on the s_ stream (tuser = command, tdata = value)
// and each produces one result on the m_ stream. Each result passes the
// registered read port of the element store (with the pending result fields)
// and then the output register; with the m_ side taking results, one command
// per cycle is sustained. Writing ring_len through the register port (clamped
// to 2..MAX_SLOTS) also empties the queue.
module ring_buffer_deque #(
  parameter int MAX_SLOTS     = rbd_pkg::MAX_SLOTS_DEF,
  parameter int ELEMENT_WIDTH = rbd_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // command stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rbd_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] value
  input  logic [rbd_pkg::S_TUSER_W-1:0]  s_tuser,  // [2:0] command
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] data_out, [35:32] count, [36] is_full, [37] is_empty, [39:38] zero
  output logic [rbd_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [rbd_pkg::M_TUSER_W-1:0]  m_tuser,  // [1:0] status
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  import rbd_pkg::*;

  localparam int PTR_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int LEN_W  = $clog2(MAX_SLOTS + 1);
  localparam int DATA_W = (ELEMENT_WIDTH < VALUE_W) ? ELEMENT_WIDTH : VALUE_W;

  logic              accept;
  logic              ready;
  pend_t             pend;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign pready   = 1'b1;
  assign s_tready = ready;
  assign accept   = s_tvalid && ready;

  rbd_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .DATA_W    (DATA_W),
    .PTR_W     (PTR_W),
    .LEN_W     (LEN_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (s_tuser[CMD_W-1:0]),
    .value   (s_tdata[VALUE_W-1:0]),
    .pend    (pend),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

  rbd_store #(
    .DEPTH  (1 << PTR_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rbd_out #(
    .DATA_W (DATA_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pend_in  (pend),
    .rd_data  (rd_data),
    .ready    (ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* src/rbd_checker.sv */
module rbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rbd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [rbd_pkg::M_TUSER_W-1:0] m_tuser
);

  import rbd_pkg::*;

  // a stalled result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result dropped or changed");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // a refused command returns no element
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> m_tdata[31:0] == '0)
    else $error("refused command returned data");

  // empty flag agrees with the count and excludes full
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[37] |-> (m_tdata[35:32] == '0) && !m_tdata[36])
    else $error("empty flag inconsistent");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
